FILE: rtl/mep_pkg.sv
// ============================================================================
// mep_pkg: shared definitions for the escape-time pixel block
// Field widths, fixed-point format, table size, operation and register codes,
// and the controller state type.
// ============================================================================
`default_nettype none

package mep_pkg;

	// Table depth and fixed-point format of the iteration
	localparam int TABLE_SIZE = 360;
	localparam int FRAC_BITS  = 28;
	localparam int INT_BITS   = 8;
	localparam int ZW         = INT_BITS + FRAC_BITS;
	localparam int TAW        = $clog2(TABLE_SIZE);

	// Input coordinate format (Q4.28)
	localparam int C_W    = 32;
	localparam int C_FRAC = 28;

	// Transaction field widths
	localparam int MODE_W   = 2;
	localparam int TIDX_W   = 9;
	localparam int COLOR_W  = 24;
	localparam int CH_W     = 8;
	localparam int LL_W     = 16;
	localparam int LL_FRAC  = 12;
	localparam int ITER_W   = 8;
	localparam int OFFSET_W = 9;

	// Configuration write channel
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int MAX_ITER_RESET = 30;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_PALETTE = 2'd0,
		MODE_LOAD_LOGLOG  = 2'd1,
		MODE_COMPUTE      = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_ITER     = 2'd0,
		CFG_COLOR_OFFSET = 2'd1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_COMB,
		ST_UPD,
		ST_IDX,
		ST_LLRD,
		ST_NORM,
		ST_MOD,
		ST_PALRD,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/mep_if.sv
// ============================================================================
// mep_if: valid/ready channels of the escape-time pixel block
// Pixel and table-load requests, pixel results, and configuration writes.
// ============================================================================
`default_nettype none

interface mep_pix_in_if;
	import mep_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic [TIDX_W-1:0]         table_index;
	logic [COLOR_W-1:0]        palette_color;
	logic signed [LL_W-1:0]    loglog_entry;
	logic signed [C_W-1:0]     c_real;
	logic signed [C_W-1:0]     c_imag;

	modport source (output valid, mode, table_index, palette_color, loglog_entry,
		c_real, c_imag, input ready);
	modport sink (input valid, mode, table_index, palette_color, loglog_entry,
		c_real, c_imag, output ready);
endinterface

interface mep_pix_out_if;
	import mep_pkg::*;

	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;
	logic [ITER_W-1:0] iterations;
	logic              escaped;

	modport source (output valid, red, green, blue, iterations, escaped, input ready);
	modport sink (input valid, red, green, blue, iterations, escaped, output ready);
endinterface

interface mep_cfg_if;
	import mep_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mandelbrot_escape_pixel.sv
// ============================================================================
// mandelbrot_escape_pixel: escape-time pixel with smooth palette coloring
// Iterates z = z*z + c in Q8.28 and maps the escape to a palette color.
// ============================================================================
`default_nettype none

// Load the palette (mode 0) and the loglog smoothing table (mode 1) before
// sending pixels (mode 2); both tables live in synchronous single-read
// memories with no reset, so an entry must be loaded before a pixel can use it,
// and a load with table_index of 360 or more is dropped. In each iteration,
// each 36x36 product is built from two 36x18 multiplies, then assembled and
// saturated, then combined into |z|^2, x*x-y*y and 2*x*y, then added to c.
// After the loop come the loglog table index, the loglog read, the smooth
// index, a reduction mod 360 of one subtract per cycle, and the palette read.
// One pixel is in flight at a time; a finished result waits in the output
// register while the next transaction is accepted.
// Configuration writes are taken only while no pixel is in flight.
module mandelbrot_escape_pixel (
	input  logic          clk,
	input  logic          arst_n,
	mep_cfg_if.sink       cfg,
	mep_pix_in_if.sink    pix_in,
	mep_pix_out_if.source pix_out
);
	import mep_pkg::*;

	localparam int HALF    = (ZW + 1) / 2;
	localparam int HI_W    = ZW - HALF;
	localparam int PL_W    = ZW + HALF;
	localparam int PH_W    = ZW + HI_W;
	localparam int FULL_W  = 2 * ZW;
	localparam int MAG_W   = FULL_W - FRAC_BITS;
	localparam int ZE_W    = ZW + 2;
	localparam int C_UP    = (FRAC_BITS >= C_FRAC) ? (FRAC_BITS - C_FRAC) : 0;
	localparam int C_DN    = (FRAC_BITS < C_FRAC) ? (C_FRAC - FRAC_BITS) : 0;
	localparam int LI_W    = ZW + 6;
	localparam int NORM_SH = LL_FRAC - 3;
	localparam int NV_W    = ITER_W + LL_FRAC + 2;
	localparam int SUM_W   = NV_W - NORM_SH;
	localparam int CMP_W   = ((TIDX_W > TAW) ? TIDX_W : TAW) + 1;

	localparam logic signed [ZW-1:0]   Z_MAX = {1'b0, {(ZW-1){1'b1}}};
	localparam logic signed [ZW-1:0]   Z_MIN = {1'b1, {(ZW-1){1'b0}}};
	localparam logic signed [ZE_W-1:0] V_MAX = ZE_W'(Z_MAX);
	localparam logic signed [ZE_W-1:0] V_MIN = ZE_W'(Z_MIN);
	localparam logic signed [ZW-1:0]   SIX   = ZW'(longint'(6) << FRAC_BITS);
	localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_W'({(ZW-1){1'b1}});
	localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(1) << (ZW - 1);
	localparam logic [LI_W-1:0]  LI_LAST     = LI_W'(TABLE_SIZE - 1);
	localparam logic [SUM_W-1:0] SUM_TSIZE   = SUM_W'(TABLE_SIZE);
	localparam logic [CMP_W-1:0] CMP_TSIZE   = CMP_W'(TABLE_SIZE);

	// Rescale a Q4.28 coordinate to the iteration format
	function automatic logic signed [ZW-1:0] c_to_z(input logic signed [C_W-1:0] c);
		logic signed [ZW+C_W-1:0] w;
		w = (ZW + C_W)'(c);
		w = (w <<< C_UP) >>> C_DN;
		return ZW'(w);
	endfunction

	// Give a truncated product magnitude its sign back, saturated
	function automatic logic signed [ZW-1:0] mag_to_z(input logic [MAG_W-1:0] mag,
		input logic neg);
		logic signed [ZW-1:0] m;
		m = signed'(ZW'(mag));
		if (!neg)
			return (mag > MAG_POS_LIM) ? Z_MAX : m;
		return (mag > MAG_NEG_LIM) ? Z_MIN : -m;
	endfunction

	// Clamp a widened sum to the iteration range
	function automatic logic signed [ZW-1:0] sat_z(input logic signed [ZE_W-1:0] v);
		if (v > V_MAX)
			return Z_MAX;
		if (v < V_MIN)
			return Z_MIN;
		return ZW'(v);
	endfunction

	state_t state_q, state_d;

	logic [ITER_W-1:0]   max_iter_q;
	logic [OFFSET_W-1:0] offset_q;

	logic signed [ZW-1:0] x_q, y_q, cr_q, ci_q, sr_q;
	logic signed [ZW-1:0] xx_q, yy_q, xy_q, xy2_q, d_q;
	logic                 xy_neg_q;
	logic [ITER_W-1:0]    n_q;

	logic [PL_W-1:0] xx_lo_q, yy_lo_q, xy_lo_q;
	logic [PH_W-1:0] xx_hi_q, yy_hi_q, xy_hi_q;

	logic [TAW-1:0]         li_q;
	logic signed [LL_W-1:0] ll_rd_q;
	logic [SUM_W-1:0]       sum_q;
	logic [COLOR_W-1:0]     pal_rd_q;

	logic [COLOR_W-1:0]     pal_mem [TABLE_SIZE];
	logic signed [LL_W-1:0] ll_mem  [TABLE_SIZE];

	logic               out_valid_q;
	logic [COLOR_W-1:0] out_rgb_q;
	logic [ITER_W-1:0]  out_iter_q;
	logic               out_esc_q;

	logic in_acc, cfg_acc, out_free, tidx_ok, esc, keep_going;
	logic [ZW-1:0]      ax, ay;
	logic [FULL_W-1:0]  xx_full, yy_full, xy_full;
	logic [LI_W-1:0]    li_full;
	logic [ITER_W:0]    n_plus1;
	logic [NV_W-1:0]    nv;
	logic [SUM_W-1:0]   norm;

	// Handshakes: configuration wins over a request in the same cycle
	assign cfg.ready    = (state_q == ST_IDLE);
	assign pix_in.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign cfg_acc      = cfg.valid && cfg.ready;
	assign in_acc       = pix_in.valid && pix_in.ready;
	assign out_free     = !out_valid_q || pix_out.ready;
	assign tidx_ok      = CMP_W'(pix_in.table_index) < CMP_TSIZE;

	// Datapath terms
	assign ax      = x_q[ZW-1] ? ZW'(-x_q) : ZW'(x_q);
	assign ay      = y_q[ZW-1] ? ZW'(-y_q) : ZW'(y_q);
	assign xx_full = FULL_W'(xx_lo_q) + (FULL_W'(xx_hi_q) << HALF);
	assign yy_full = FULL_W'(yy_lo_q) + (FULL_W'(yy_hi_q) << HALF);
	assign xy_full = FULL_W'(xy_lo_q) + (FULL_W'(xy_hi_q) << HALF);
	assign li_full = (LI_W'(sr_q) * LI_W'(45)) >> (FRAC_BITS + 3);
	assign n_plus1 = (ITER_W + 1)'(n_q) + 1'b1;
	assign nv      = (NV_W'(n_plus1) << LL_FRAC) - NV_W'(ll_rd_q);
	assign norm    = nv[NV_W-1] ? '0 : SUM_W'(nv[NV_W-1:NORM_SH]);
	assign esc     = (n_q != max_iter_q);
	assign keep_going = (n_plus1 < (ITER_W + 1)'(max_iter_q)) && (sr_q < SIX);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= ITER_W'(MAX_ITER_RESET);
			offset_q   <= '0;
		end else if (cfg_acc) begin
			unique case (cfg.index)
				CFG_MAX_ITER:     max_iter_q <= cfg.data[ITER_W-1:0];
				CFG_COLOR_OFFSET: offset_q   <= cfg.data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && pix_in.mode == MODE_COMPUTE)
					state_d = (max_iter_q != '0) ? ST_MUL : ST_IDX;
			end
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_COMB;
			ST_COMB: state_d = ST_UPD;
			ST_UPD:  state_d = keep_going ? ST_MUL : ST_IDX;
			ST_IDX:  state_d = ST_LLRD;
			ST_LLRD: state_d = ST_NORM;
			ST_NORM: state_d = ST_MOD;
			ST_MOD: begin
				if (sum_q < SUM_TSIZE)
					state_d = ST_PALRD;
			end
			ST_PALRD: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Iteration and coloring datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_q  <= c_to_z(pix_in.c_real);
					y_q  <= c_to_z(pix_in.c_imag);
					cr_q <= c_to_z(pix_in.c_real);
					ci_q <= c_to_z(pix_in.c_imag);
					sr_q <= '0;
					n_q  <= '0;
				end
			end
			ST_MUL: begin
				xx_lo_q  <= ax * ax[HALF-1:0];
				xx_hi_q  <= ax * ax[ZW-1:HALF];
				yy_lo_q  <= ay * ay[HALF-1:0];
				yy_hi_q  <= ay * ay[ZW-1:HALF];
				xy_lo_q  <= ax * ay[HALF-1:0];
				xy_hi_q  <= ax * ay[ZW-1:HALF];
				xy_neg_q <= x_q[ZW-1] ^ y_q[ZW-1];
			end
			ST_SUM: begin
				xx_q <= mag_to_z(xx_full[FULL_W-1:FRAC_BITS], 1'b0);
				yy_q <= mag_to_z(yy_full[FULL_W-1:FRAC_BITS], 1'b0);
				xy_q <= mag_to_z(xy_full[FULL_W-1:FRAC_BITS], xy_neg_q);
			end
			ST_COMB: begin
				sr_q  <= sat_z(ZE_W'(xx_q) + ZE_W'(yy_q));
				d_q   <= sat_z(ZE_W'(xx_q) - ZE_W'(yy_q));
				xy2_q <= sat_z(ZE_W'(xy_q) + ZE_W'(xy_q));
			end
			ST_UPD: begin
				x_q <= sat_z(ZE_W'(d_q) + ZE_W'(cr_q));
				y_q <= sat_z(ZE_W'(xy2_q) + ZE_W'(ci_q));
				n_q <= n_q + 1'b1;
			end
			ST_IDX: begin
				li_q <= (li_full > LI_LAST) ? TAW'(TABLE_SIZE - 1) : TAW'(li_full);
			end
			ST_NORM: begin
				sum_q <= esc ? (norm + SUM_W'(offset_q)) : '0;
			end
			ST_MOD: begin
				if (sum_q >= SUM_TSIZE)
					sum_q <= sum_q - SUM_TSIZE;
			end
			default: ;
		endcase
	end

	// Palette memory: load in idle, read after the index is reduced
	always_ff @(posedge clk) begin
		if (in_acc && pix_in.mode == MODE_LOAD_PALETTE && tidx_ok)
			pal_mem[TAW'(pix_in.table_index)] <= pix_in.palette_color;
		if (state_q == ST_PALRD)
			pal_rd_q <= pal_mem[TAW'(sum_q)];
	end

	// Loglog memory: load in idle, read once the loop has ended
	always_ff @(posedge clk) begin
		if (in_acc && pix_in.mode == MODE_LOAD_LOGLOG && tidx_ok)
			ll_mem[TAW'(pix_in.table_index)] <= pix_in.loglog_entry;
		if (state_q == ST_LLRD)
			ll_rd_q <= ll_mem[li_q];
	end

	// Output register: advance when empty or drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_rgb_q  <= esc ? pal_rd_q : '0;
			out_iter_q <= n_q;
			out_esc_q  <= esc;
		end
	end

	assign pix_out.valid      = out_valid_q;
	assign pix_out.red        = out_rgb_q[3*CH_W-1:2*CH_W];
	assign pix_out.green      = out_rgb_q[2*CH_W-1:CH_W];
	assign pix_out.blue       = out_rgb_q[CH_W-1:0];
	assign pix_out.iterations = out_iter_q;
	assign pix_out.escaped    = out_esc_q;

	// Checks
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (n_q <= max_iter_q))
		else $error("iteration count passed the limit");

	a_sr_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> !sr_q[ZW-1])
		else $error("squared magnitude went negative");

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PALRD) |-> (sum_q < SUM_TSIZE))
		else $error("palette index not reduced below table size");

	a_pixel_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && pix_in.mode == MODE_COMPUTE) |=> (state_q == ST_MUL || state_q == ST_IDX))
		else $error("pixel transaction did not start iterating");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.escaped) |->
		(pix_out.red == '0 && pix_out.green == '0 && pix_out.blue == '0))
		else $error("non-escaped pixel is not black");

	a_esc_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.escaped) |-> (pix_out.iterations != '0))
		else $error("escaped pixel reports zero iterations");

endmodule

`default_nettype wire
